// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

   // Sizing
   localparam int SLOTS        = 16;
   localparam int SIZE_BITS    = 16;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FIELD_W      = 16;
   localparam int SLOT_FIELD_W = 4;
   localparam int MODE_W       = 2;
   localparam int COUNT_W      = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 5;

   // Placement policies
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 1'b1;

   // Register reset values
   localparam logic [MODE_W-1:0]  FIT_MODE_RESET = MODE_FIRST;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 5'd16;

   // Running candidate handed from cell to cell
   typedef struct packed {
      logic                 found;
      logic [SLOT_W-1:0]    idx;
      logic [SIZE_BITS-1:0] hole;
   } cand_type;

   // Broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic                 copy;
      logic [SIZE_BITS-1:0] load_value;
      logic [SIZE_BITS-1:0] want;
      logic [MODE_W-1:0]    mode;
      logic [COUNT_W-1:0]   count;
      logic                 wr_en;
      logic [SLOT_W-1:0]    wr_slot;
      logic [SIZE_BITS-1:0] wr_value;
   } cell_ctrl_type;

endpackage

// ===== sv/fpa_if.sv =====
interface fpa_req_if import fpa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SLOT_FIELD_W-1:0] slot;
   logic [FIELD_W-1:0]      load_size;
   logic [FIELD_W-1:0]      request_size;
   logic                    first_request;

   modport source (output valid, kind, slot, load_size, request_size, first_request,
                   input ready);
   modport sink   (input valid, kind, slot, load_size, request_size, first_request,
                   output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    granted;
   logic [SLOT_FIELD_W-1:0] slot_taken;
   logic [FIELD_W-1:0]      hole_before;
   logic [FIELD_W-1:0]      hole_after;
   logic                    all_served;

   modport source (output valid, granted, slot_taken, hole_before, hole_after, all_served,
                   input ready);
   modport sink   (input valid, granted, slot_taken, hole_before, hole_after, all_served,
                   output ready);
endinterface

interface fpa_csr_if import fpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fpa_cell.sv =====
module fpa_cell import fpa_pkg::*; (
   input  logic              clock,
   input  logic [SLOT_W-1:0] idx,
   input  logic              load_hit,
   input  cell_ctrl_type     ctrl,
   input  cand_type          cand_prev,
   output cand_type          cand_next
);

   logic [SIZE_BITS-1:0] loaded_ff, loaded_in;
   logic [SIZE_BITS-1:0] hole_ff, hole_in;
   cand_type             cand_ff, cand_in;
   logic                 active;
   logic                 fits;
   logic                 take;

   // Partition storage: load, restart copy, write-back of a placement
   always_comb begin
      loaded_in = load_hit ? ctrl.load_value : loaded_ff;
      hole_in   = hole_ff;
      if (ctrl.copy) begin
         hole_in = loaded_ff;
      end else if (ctrl.wr_en && (ctrl.wr_slot == idx)) begin
         hole_in = ctrl.wr_value;
      end
   end

   // Policy compare against the candidate from the left neighbor
   assign active = (32'(idx) < 32'(ctrl.count));
   assign fits   = (hole_ff >= ctrl.want);

   always_comb begin
      case (ctrl.mode)
         MODE_BEST:  take = fits && (!cand_prev.found || (hole_ff < cand_prev.hole));
         MODE_WORST: take = !cand_prev.found || (hole_ff > cand_prev.hole);
         default:    take = fits && !cand_prev.found;
      endcase
      cand_in = cand_prev;
      if (active && take) begin
         cand_in.found = 1'b1;
         cand_in.idx   = idx;
         cand_in.hole  = hole_ff;
      end
   end

   always_ff @(posedge clock) begin
      loaded_ff <= loaded_in;
      hole_ff   <= hole_in;
      cand_ff   <= cand_in;
   end

   assign cand_next = cand_ff;

endmodule

// ===== sv/fit_policy_partition_allocator.sv =====
// Channel   Dir   Transfer when         Payload
// req_chan  in    valid && ready        kind, slot, load_size, request_size, first_request
// rsp_chan  out   valid && ready        granted, slot_taken, hole_before, hole_after, all_served
// csr_chan  in    valid && ready        index, data (ready high out of reset)
//
// A load is stored in its slot on its accept edge. A request scans the row of cells: the
// candidate walks the row one slot per cycle, then the placement state places it.
// A first request copies loaded sizes to holes on its accept edge.
// Reset returns control and the registers to their defaults and sets the all-served
// flag; sizes are unknown. No transfer is taken on req or csr while reset is high.
// The result register holds while rsp is stalled; the next item may still be taken,
// and a second request waits at placement until the result register frees up.
module fit_policy_partition_allocator import fpa_pkg::*; (
   input logic       clock,
   input logic       reset,
   fpa_req_if.sink   req_chan,
   fpa_rsp_if.source rsp_chan,
   fpa_csr_if.sink   csr_chan
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PLACE} state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    cnt_ff;
   logic [SIZE_BITS-1:0] want_ff;
   logic                 served_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [COUNT_W-1:0]   count_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_granted_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [FIELD_W-1:0]      rsp_before_ff;
   logic [FIELD_W-1:0]      rsp_after_ff;
   logic                    rsp_served_ff;

   logic                 req_xfer;
   logic                 load_xfer;
   logic                 ask_xfer;
   logic                 rsp_free;
   logic                 place;
   logic                 grant;
   logic [SIZE_BITS-1:0] after_value;
   cell_ctrl_type        ctrl;
   cand_type             chain [SLOTS+1];
   logic [SLOTS-1:0]     load_hit;

   // Handshakes
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign load_xfer      = req_xfer && !req_chan.kind;
   assign ask_xfer       = req_xfer && req_chan.kind;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign place          = (state_ff == S_PLACE) && rsp_free;
   assign csr_chan.ready = !reset;

   // Final pick from the end of the row
   assign grant       = chain[SLOTS].found && (chain[SLOTS].hole >= want_ff);
   assign after_value = chain[SLOTS].hole - want_ff;

   // Broadcast controls
   always_comb begin
      ctrl.copy       = ask_xfer && req_chan.first_request;
      ctrl.load_value = SIZE_BITS'(req_chan.load_size);
      ctrl.want       = want_ff;
      ctrl.mode       = mode_ff;
      ctrl.count      = count_ff;
      ctrl.wr_en      = place && grant;
      ctrl.wr_slot    = chain[SLOTS].idx;
      ctrl.wr_value   = after_value;
   end

   // Row of cells
   assign chain[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      assign load_hit[i] = load_xfer && (32'(req_chan.slot) == i);

      fpa_cell u_cell (
         .clock     (clock),
         .idx       (SLOT_W'(i)),
         .load_hit  (load_hit[i]),
         .ctrl      (ctrl),
         .cand_prev (chain[i]),
         .cand_next (chain[i+1])
      );
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= FIT_MODE_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_FIT_MODE:     mode_ff  <= csr_chan.data[MODE_W-1:0];
            CSR_SLOTS_IN_USE: count_ff <= csr_chan.data[COUNT_W-1:0];
            default:          ;
         endcase
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         served_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result valid: set on placement, cleared when the transfer completes
         if (place) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (ask_xfer) begin
                  want_ff  <= SIZE_BITS'(req_chan.request_size);
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
                  if (req_chan.first_request) begin
                     served_ff <= 1'b1;
                  end
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               if (rsp_free) begin
                  rsp_granted_ff <= grant;
                  rsp_served_ff  <= served_ff && grant;
                  served_ff      <= served_ff && grant;
                  if (grant) begin
                     rsp_slot_ff   <= SLOT_FIELD_W'(chain[SLOTS].idx);
                     rsp_before_ff <= FIELD_W'(chain[SLOTS].hole);
                     rsp_after_ff  <= FIELD_W'(after_value);
                  end else begin
                     rsp_slot_ff   <= '0;
                     rsp_before_ff <= '0;
                     rsp_after_ff  <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.granted     = rsp_granted_ff;
   assign rsp_chan.slot_taken  = rsp_slot_ff;
   assign rsp_chan.hole_before = rsp_before_ff;
   assign rsp_chan.hole_after  = rsp_after_ff;
   assign rsp_chan.all_served  = rsp_served_ff;

   // Checks
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cnt_ff == SLOT_W'(SLOTS - 1)) |=> (state_ff == S_PLACE))
      else $error("scan did not end after one pass over the row");

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |->
      (rsp_slot_ff == '0 && rsp_before_ff == '0 && rsp_after_ff == '0 && !rsp_served_ff))
      else $error("refused request carries placement data or served flag");

   a_grant_shrinks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff) |-> (rsp_after_ff <= rsp_before_ff))
      else $error("granted placement grew the hole");

   a_place_write: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |=> (rsp_valid_ff && rsp_granted_ff && state_ff == S_IDLE))
      else $error("hole write-back without a granted result");

endmodule
